// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the mailbox engine RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMSE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mailbox engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PMSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mailbox engine check failed");

`endif

// ===== hdl/pmse_pkg.sv =====
// Shared types and constants for the partition mailbox system-call engine.
// No dependencies; imported by every module of the block.
package pmse_pkg;

  // Width of the pc, the peer number and the message words on the ports.
  localparam int FIELD_W   = 32;
  localparam int OP_W      = 3;
  localparam int CALLER_W  = 3;
  localparam int MSG_WORDS = 4;

  // Defaults for the top-level parameters.
  localparam int PARTITIONS_DEF = 8;
  localparam int WORD_WIDTH_DEF = 32;

  // System-call numbers.
  localparam logic [OP_W-1:0] OP_YIELD  = 3'd0;
  localparam logic [OP_W-1:0] OP_SEND   = 3'd1;
  localparam logic [OP_W-1:0] OP_RECV   = 3'd2;
  localparam logic [OP_W-1:0] OP_WAIT_A = 3'd3;
  localparam logic [OP_W-1:0] OP_WAIT_B = 3'd4;

  // Step from the calling instruction to the resume pc.
  localparam logic [FIELD_W-1:0] PC_STEP = 32'd4;

  // Mailbox access request from the decoder to the slot store.
  typedef struct packed {
    logic send_try;
    logic recv_try;
  } pmse_req_t;

  // One message of four port-width words.
  typedef logic [MSG_WORDS-1:0][FIELD_W-1:0] pmse_msg_t;

endpackage

// ===== hdl/pmse_decode.sv =====
// Call decoder: classifies one system call, checks partition ranges,
// forms the mailbox slot index and the resume pc. Depends on pmse_pkg.
module pmse_decode import pmse_pkg::*; #(
  parameter int PARTITIONS = PARTITIONS_DEF,
  parameter int PART_W     = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1,
  parameter int SLOT_W     = 2 * PART_W
) (
  input  logic                valid,
  input  logic [OP_W-1:0]     op,
  input  logic [CALLER_W-1:0] caller,
  input  logic [FIELD_W-1:0]  peer,
  input  logic [FIELD_W-1:0]  return_pc,
  output pmse_req_t           req,
  output logic [SLOT_W-1:0]   slot_idx,
  output logic                status_valid,
  output logic                trap,
  output logic [FIELD_W-1:0]  next_pc
);

  logic              caller_ok;
  logic              peer_ok;
  logic [PART_W-1:0] caller_ix;
  logic [PART_W-1:0] peer_ix;

  // Range checks against the partition count.
  assign caller_ok = FIELD_W'(caller) < FIELD_W'(PARTITIONS);
  assign peer_ok   = peer < FIELD_W'(PARTITIONS);
  assign caller_ix = PART_W'(caller);
  assign peer_ix   = peer[PART_W-1:0];

  // Per-call decode. Slots are indexed by receiver, then sender.
  always_comb begin
    req          = '0;
    slot_idx     = '0;
    status_valid = 1'b0;
    trap         = 1'b0;
    next_pc      = return_pc + PC_STEP;
    case (op)
      OP_YIELD: begin
        trap = !peer_ok;
      end
      OP_SEND: begin
        status_valid = 1'b1;
        req.send_try = valid && caller_ok && peer_ok;
        slot_idx     = {peer_ix, caller_ix};
      end
      OP_RECV: begin
        status_valid = 1'b1;
        req.recv_try = valid && caller_ok && peer_ok;
        slot_idx     = {caller_ix, peer_ix};
      end
      OP_WAIT_A, OP_WAIT_B: begin
        trap = 1'b0;
      end
      default: begin
        // Unknown call number: trap and resume at the calling instruction.
        trap    = 1'b1;
        next_pc = return_pc;
      end
    endcase
  end

endmodule

// ===== hdl/pmse_store.sv =====
// Mailbox slot store: full flags in flip-flops and the message memory,
// one row of four words per slot. Depends on pmse_pkg.
module pmse_store import pmse_pkg::*; #(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  parameter int SLOT_W     = 6,
  parameter int SLOTS      = 1 << SLOT_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pmse_req_t         req,
  input  logic [SLOT_W-1:0] slot_idx,
  input  pmse_msg_t         wr_words,
  output logic              hit,
  output pmse_msg_t         rd_words
);

  typedef logic [MSG_WORDS-1:0][WORD_WIDTH-1:0] row_t;

  logic [SLOTS-1:0] full_r;
  logic [SLOTS-1:0] full_nxt;
  row_t             mem_r [SLOTS];
  row_t             wr_row;
  row_t             rd_row_r;
  logic             slot_full;
  logic             wr_en;
  logic             clr_en;

  // Success check: a send needs an empty slot, a receive a full one.
  assign slot_full = full_r[slot_idx];
  assign wr_en     = req.send_try && !slot_full;
  assign clr_en    = req.recv_try && slot_full;
  assign hit       = wr_en || clr_en;

  // Full flag update.
  always_comb begin
    full_nxt = full_r;
    if (wr_en) begin
      full_nxt[slot_idx] = 1'b1;
    end else if (clr_en) begin
      full_nxt[slot_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= '0;
    end else begin
      full_r <= full_nxt;
    end
  end

  // Words are kept at the storage width, zero extended from the port.
  always_comb begin
    for (int i = 0; i < MSG_WORDS; i++) begin
      wr_row[i] = WORD_WIDTH'(wr_words[i]);
    end
  end

  // Message memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[slot_idx] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (req.recv_try) begin
      rd_row_r <= mem_r[slot_idx];
    end
  end

  // Words leave at port width.
  always_comb begin
    for (int i = 0; i < MSG_WORDS; i++) begin
      rd_words[i] = rd_row_r[i][FIELD_W-1:0];
    end
  end

endmodule

// ===== hdl/partition_mailbox_syscall_engine_top.sv =====
// Top level of the partition mailbox system-call engine.
// Depends on pmse_pkg, pmse_decode, pmse_store and assert_macros.svh.
//
// Usage:
//   Input channel: a call word (in_op, in_caller, in_peer, in_return_pc,
//   in_word0..in_word3) is taken at a rising edge where start is high and
//   busy is low. busy stays low, so a new call can be issued every cycle.
//   Result channel: each call gives exactly one result word, shown on the
//   out_ ports for one cycle while out_strobe is high. The receiver cannot
//   stall; it must take the word in that cycle.
//   Path: a call passes the input register, then the result register and the
//   message read register, which are loaded together.
//   Throughput: one call per cycle. Each call reads and updates one mailbox
//   slot in a single pass; a slot written by one call is visible to the next.
//   Reset: synchronous, active low. All full flags are cleared at once and
//   no call is in flight afterwards. Message words need no clearing, since a
//   slot's words reach the out_ ports only on a receive that finds it full.
`include "assert_macros.svh"

module partition_mailbox_syscall_engine_top import pmse_pkg::*; #(
  parameter int PARTITIONS = PARTITIONS_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     in_op,
  input  logic [CALLER_W-1:0] in_caller,
  input  logic [FIELD_W-1:0]  in_peer,
  input  logic [FIELD_W-1:0]  in_return_pc,
  input  logic [FIELD_W-1:0]  in_word0,
  input  logic [FIELD_W-1:0]  in_word1,
  input  logic [FIELD_W-1:0]  in_word2,
  input  logic [FIELD_W-1:0]  in_word3,
  output logic                out_strobe,
  output logic                out_status_valid,
  output logic                out_status_ok,
  output logic                out_trap,
  output logic [FIELD_W-1:0]  out_next_pc,
  output logic [FIELD_W-1:0]  out_word0,
  output logic [FIELD_W-1:0]  out_word1,
  output logic [FIELD_W-1:0]  out_word2,
  output logic [FIELD_W-1:0]  out_word3
);

  localparam int PART_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int SLOT_W = 2 * PART_W;
  localparam int SLOTS  = 1 << SLOT_W;

  logic                accept;
  logic                valid_a_r;
  logic [OP_W-1:0]     op_a_r;
  logic [CALLER_W-1:0] caller_a_r;
  logic [FIELD_W-1:0]  peer_a_r;
  logic [FIELD_W-1:0]  pc_a_r;
  pmse_msg_t           words_a_r;

  pmse_req_t           req;
  logic [SLOT_W-1:0]   slot_idx;
  logic                dec_status_valid;
  logic                dec_trap;
  logic [FIELD_W-1:0]  dec_next_pc;
  logic                hit;
  pmse_msg_t           rd_words;

  logic                out_strobe_r;
  logic                status_valid_r;
  logic                status_ok_r;
  logic                trap_r;
  logic [FIELD_W-1:0]  next_pc_r;
  logic                rx_ok_r;

  // The engine takes a call every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else begin
      valid_a_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_a_r     <= in_op;
      caller_a_r <= in_caller;
      peer_a_r   <= in_peer;
      pc_a_r     <= in_return_pc;
      words_a_r  <= {in_word3, in_word2, in_word1, in_word0};
    end
  end

  // Call decode.
  pmse_decode #(
    .PARTITIONS (PARTITIONS),
    .PART_W     (PART_W),
    .SLOT_W     (SLOT_W)
  ) u_decode (
    .valid        (valid_a_r),
    .op           (op_a_r),
    .caller       (caller_a_r),
    .peer         (peer_a_r),
    .return_pc    (pc_a_r),
    .req          (req),
    .slot_idx     (slot_idx),
    .status_valid (dec_status_valid),
    .trap         (dec_trap),
    .next_pc      (dec_next_pc)
  );

  // Mailbox flags and message memory.
  pmse_store #(
    .WORD_WIDTH (WORD_WIDTH),
    .SLOT_W     (SLOT_W),
    .SLOTS      (SLOTS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .slot_idx (slot_idx),
    .wr_words (words_a_r),
    .hit      (hit),
    .rd_words (rd_words)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_a_r) begin
      status_valid_r <= dec_status_valid;
      status_ok_r    <= hit;
      trap_r         <= dec_trap;
      next_pc_r      <= dec_next_pc;
      rx_ok_r        <= req.recv_try && hit;
    end
  end

  // Received words show only on a successful receive.
  assign out_strobe       = out_strobe_r;
  assign out_status_valid = status_valid_r;
  assign out_status_ok    = status_ok_r;
  assign out_trap         = trap_r;
  assign out_next_pc      = next_pc_r;
  assign out_word0        = rx_ok_r ? rd_words[0] : '0;
  assign out_word1        = rx_ok_r ? rd_words[1] : '0;
  assign out_word2        = rx_ok_r ? rd_words[2] : '0;
  assign out_word3        = rx_ok_r ? rd_words[3] : '0;

  // Every call in the input register yields a result word from the result register.
  `PMSE_ASSERT_NEXT(a_result_follows, clk, rst_n, valid_a_r, out_strobe_r)
  // A strobe is never raised without a call in the input register.
  `PMSE_ASSERT_IMPLY(a_no_spurious, clk, rst_n, out_strobe_r, $past(valid_a_r))
  // Success is reported only for send and receive, which never trap.
  `PMSE_ASSERT_IMPLY(a_ok_is_status, clk, rst_n, out_strobe_r && out_status_ok,
                     out_status_valid && !out_trap)
  // A failed call returns no message words.
  `PMSE_ASSERT_IMPLY(a_words_zero, clk, rst_n, out_strobe_r && !out_status_ok,
                     out_word0 == '0 && out_word1 == '0 && out_word2 == '0 && out_word3 == '0)

endmodule
